[sv/fresnel_dielectric_reflectance_unit_assert.svh]
// Assertion macros shared by the Fresnel reflectance RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef FRESNEL_DIELECTRIC_REFLECTANCE_UNIT_ASSERT_SVH
`define FRESNEL_DIELECTRIC_REFLECTANCE_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define FDR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/fdr_pkg.sv]
// Shared types and constants for the Fresnel reflectance pipeline.
// No dependencies.
`timescale 1ns / 1ps

package fdr_pkg;

  localparam logic signed [15:0] CosOne    = 16'sd16384;
  localparam logic [14:0]        CosOneMag = 15'd16384;
  localparam logic [28:0]        OneQ28    = 29'h1000_0000;
  localparam logic [16:0]        OneQ16    = 17'h1_0000;

  localparam int S2tSteps   = 28;  // quotient bits of sin^2 transmitted
  localparam int SqrtSteps  = 15;  // root bits of cos transmitted
  localparam int RatioSteps = 25;  // quotient bits of amplitude ratios
  localparam int NumW       = 60;  // a^2 * sin^2 incident
  localparam int RemW       = 56;  // |n| << 24

  typedef struct packed {
    logic [14:0] c;  // |cos incident|, Q14
    logic [15:0] a;  // index on incident side after swap
    logic [15:0] b;  // index on transmitted side after swap
  } ray_t;

endpackage

[sv/fdr_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
// Depends on fdr_pkg; carries the ray payload alongside.
`timescale 1ns / 1ps

module fdr_sqrt import fdr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [28:0] rad_i,
  input  ray_t        ray_i,
  output logic        valid_o,
  output logic [14:0] root_o,
  output ray_t        ray_o
);

  logic        v_q   [0:SqrtSteps];
  logic [28:0] rad_q [0:SqrtSteps];
  logic [29:0] res_q [0:SqrtSteps];
  ray_t        ray_q [0:SqrtSteps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q[0] <= rad_i;
      res_q[0] <= '0;
      ray_q[0] <= ray_i;
    end
  end

  for (genvar j = 0; j < SqrtSteps; j++) begin : g_step
    logic [29:0] bitc;
    logic [29:0] sum;
    logic        take;

    assign bitc = 30'(1) << (2 * (SqrtSteps - 1 - j));
    assign sum  = res_q[j] + bitc;
    assign take = {1'b0, rad_q[j]} >= sum;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[j+1] <= take ? (rad_q[j] - sum[28:0]) : rad_q[j];
        res_q[j+1] <= take ? ((res_q[j] >> 1) + bitc) : (res_q[j] >> 1);
        ray_q[j+1] <= ray_q[j];
      end
    end
  end

  assign valid_o = v_q[SqrtSteps];
  assign root_o  = res_q[SqrtSteps][14:0];
  assign ray_o   = ray_q[SqrtSteps];

endmodule

[sv/fdr_ratio.sv]
// Two-lane pipelined restoring divider for |p-m| * 2^24 / (p+m).
// Depends on fdr_pkg; flags a zero denominator in either lane.
`timescale 1ns / 1ps

module fdr_ratio import fdr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [30:0] p1_i,
  input  logic [30:0] m1_i,
  input  logic [30:0] p2_i,
  input  logic [30:0] m2_i,
  output logic        valid_o,
  output logic        zero_o,
  output logic [24:0] q1_o,
  output logic [24:0] q2_o
);

  logic            v_q    [0:RatioSteps];
  logic            zero_q [0:RatioSteps];
  logic [31:0]     d1_q   [0:RatioSteps];
  logic [31:0]     d2_q   [0:RatioSteps];
  logic [RemW-1:0] r1_q   [0:RatioSteps];
  logic [RemW-1:0] r2_q   [0:RatioSteps];
  logic [24:0]     q1_q   [0:RatioSteps];
  logic [24:0]     q2_q   [0:RatioSteps];

  logic [31:0] d1, d2;
  logic [30:0] mag1, mag2;

  assign d1   = 32'(p1_i) + 32'(m1_i);
  assign d2   = 32'(p2_i) + 32'(m2_i);
  assign mag1 = (p1_i >= m1_i) ? (p1_i - m1_i) : (m1_i - p1_i);
  assign mag2 = (p2_i >= m2_i) ? (p2_i - m2_i) : (m2_i - p2_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (d1 == '0) || (d2 == '0);
      d1_q[0]   <= d1;
      d2_q[0]   <= d2;
      r1_q[0]   <= {1'b0, mag1, 24'b0};
      r2_q[0]   <= {1'b0, mag2, 24'b0};
      q1_q[0]   <= '0;
      q2_q[0]   <= '0;
    end
  end

  for (genvar j = 0; j < RatioSteps; j++) begin : g_step
    logic [RemW-1:0] t1, t2;
    logic            k1, k2;
    logic [24:0]     qbit;

    assign t1   = RemW'(d1_q[j]) << (RatioSteps - 1 - j);
    assign t2   = RemW'(d2_q[j]) << (RatioSteps - 1 - j);
    assign k1   = r1_q[j] >= t1;
    assign k2   = r2_q[j] >= t2;
    assign qbit = 25'(1) << (RatioSteps - 1 - j);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[j+1] <= zero_q[j];
        d1_q[j+1]   <= d1_q[j];
        d2_q[j+1]   <= d2_q[j];
        r1_q[j+1]   <= k1 ? (r1_q[j] - t1) : r1_q[j];
        r2_q[j+1]   <= k2 ? (r2_q[j] - t2) : r2_q[j];
        q1_q[j+1]   <= k1 ? (q1_q[j] | qbit) : q1_q[j];
        q2_q[j+1]   <= k2 ? (q2_q[j] | qbit) : q2_q[j];
      end
    end
  end

  assign valid_o = v_q[RatioSteps];
  assign zero_o  = zero_q[RatioSteps];
  assign q1_o    = q1_q[RatioSteps];
  assign q2_o    = q2_q[RatioSteps];

endmodule

[sv/fresnel_dielectric_reflectance_unit.sv]
// Unpolarized dielectric Fresnel reflectance, fully pipelined.
// Depends on fdr_pkg, fdr_sqrt, fdr_ratio and the assertion macro header.
//
// Input channel: in_valid_i / in_stall_o with cos_incident_i (Q2.14 signed)
// and the two indices (Q4.12). Output channel: out_valid_o / out_stall_i with
// reflectance_o (Q1.16, 65536 = 1.0). A transaction moves when valid is high
// and stall is low.
// Throughput: one transaction per cycle while in_stall_o is low; the sin^2
// divider (28 stages), the root (15 stages) and the ratio divider (25
// stages) each retire one bit per stage.
// Reset clears all valid bits; the pipeline comes up empty and ready.
// When the receiver stalls, the output register holds its result and the
// pipeline keeps moving until the next result lands in a skid register;
// in_stall_o then rises (registered) and the whole pipeline freezes until
// the skid register drains. Nothing is dropped or duplicated.
`timescale 1ns / 1ps

module fresnel_dielectric_reflectance_unit import fdr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] cos_incident_i,
  input  logic [15:0]        index_incident_i,
  input  logic [15:0]        index_transmitted_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [16:0]        reflectance_o
);

  `include "fresnel_dielectric_reflectance_unit_assert.svh"

  logic en;
  logic skid_q, out_valid_q;
  logic [16:0] skid_data_q, out_data_q;

  assign en         = !skid_q;
  assign in_stall_o = skid_q;

  // Clamp and orient: a non-positive cosine swaps the indices.
  ray_t        ray_in;
  logic [15:0] cos_neg;
  assign cos_neg = 16'(-cos_incident_i);

  always_comb begin
    ray_in.a = index_incident_i;
    ray_in.b = index_transmitted_i;
    ray_in.c = cos_incident_i[14:0];
    if (cos_incident_i > CosOne) begin
      ray_in.c = CosOneMag;
    end else if (cos_incident_i < -CosOne) begin
      ray_in.a = index_transmitted_i;
      ray_in.b = index_incident_i;
      ray_in.c = CosOneMag;
    end else if (cos_incident_i <= 16'sd0) begin
      ray_in.a = index_transmitted_i;
      ray_in.b = index_incident_i;
      ray_in.c = cos_neg[14:0];
    end
  end

  // Stage 0: oriented ray.
  logic s0_v_q;
  ray_t s0_ray_q;
  // Stage 1: squares.
  logic        s1_v_q;
  ray_t        s1_ray_q;
  logic [31:0] s1_a2_q, s1_b2_q;
  logic [28:0] s1_s2i_q;
  // Stage 2: numerator a^2 * sin^2 incident.
  logic            s2_v_q;
  ray_t            s2_ray_q;
  logic [31:0]     s2_b2_q;
  logic [NumW-1:0] s2_num_q;
  logic            s2_bz_q, s2_s2i_nz_q;

  logic [29:0] csq;
  logic [60:0] num_full;
  assign csq      = {15'b0, s0_ray_q.c} * {15'b0, s0_ray_q.c};
  assign num_full = {29'b0, s1_a2_q} * {32'b0, s1_s2i_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q <= in_valid_i;
      s1_v_q <= s0_v_q;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_ray_q    <= ray_in;
      s1_ray_q    <= s0_ray_q;
      s1_a2_q     <= {16'b0, s0_ray_q.a} * {16'b0, s0_ray_q.a};
      s1_b2_q     <= {16'b0, s0_ray_q.b} * {16'b0, s0_ray_q.b};
      s1_s2i_q    <= 29'({1'b0, OneQ28} - csq);
      s2_ray_q    <= s1_ray_q;
      s2_b2_q     <= s1_b2_q;
      s2_num_q    <= num_full[NumW-1:0];
      s2_bz_q     <= (s1_ray_q.b == '0);
      s2_s2i_nz_q <= (s1_s2i_q != '0);
    end
  end

  // sin^2 transmitted divider; entry 0 holds the saturation check.
  logic            dv_v_q   [0:S2tSteps];
  logic            dv_sat_q [0:S2tSteps];
  logic [31:0]     dv_b2_q  [0:S2tSteps];
  logic [NumW-1:0] dv_rem_q [0:S2tSteps];
  logic [27:0]     dv_q_q   [0:S2tSteps];
  ray_t            dv_ray_q [0:S2tSteps];

  logic s2t_sat;
  // Zero transmitted index: full saturation unless sin^2 incident is zero.
  assign s2t_sat = s2_bz_q ? s2_s2i_nz_q : (s2_num_q >= {s2_b2_q, 28'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (en) begin
      dv_v_q[0] <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_sat_q[0] <= s2t_sat;
      dv_b2_q[0]  <= s2_b2_q;
      dv_rem_q[0] <= s2_num_q;
      dv_q_q[0]   <= '0;
      dv_ray_q[0] <= s2_ray_q;
    end
  end

  for (genvar j = 0; j < S2tSteps; j++) begin : g_s2t
    logic [NumW-1:0] trial;
    logic            take;
    logic [27:0]     qbit;

    assign trial = NumW'(dv_b2_q[j]) << (S2tSteps - 1 - j);
    assign take  = dv_rem_q[j] >= trial;
    assign qbit  = 28'(1) << (S2tSteps - 1 - j);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j+1] <= 1'b0;
      end else if (en) begin
        dv_v_q[j+1] <= dv_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_sat_q[j+1] <= dv_sat_q[j];
        dv_b2_q[j+1]  <= dv_b2_q[j];
        dv_rem_q[j+1] <= take ? (dv_rem_q[j] - trial) : dv_rem_q[j];
        dv_q_q[j+1]   <= take ? (dv_q_q[j] | qbit) : dv_q_q[j];
        dv_ray_q[j+1] <= dv_ray_q[j];
      end
    end
  end

  logic [28:0] c2t;
  assign c2t = dv_sat_q[S2tSteps] ? '0 : (OneQ28 - {1'b0, dv_q_q[S2tSteps]});

  logic        rt_v;
  logic [14:0] rt_ct;
  ray_t        rt_ray;

  fdr_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_v_q[S2tSteps]),
    .rad_i   (c2t),
    .ray_i   (dv_ray_q[S2tSteps]),
    .valid_o (rt_v),
    .root_o  (rt_ct),
    .ray_o   (rt_ray)
  );

  // Products of the amplitude terms, Q26.
  logic        pr_v_q;
  logic [30:0] pr_p1_q, pr_m1_q, pr_p2_q, pr_m2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_v_q <= 1'b0;
    end else if (en) begin
      pr_v_q <= rt_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr_p1_q <= {15'b0, rt_ray.b} * {16'b0, rt_ray.c};
      pr_m1_q <= {15'b0, rt_ray.a} * {16'b0, rt_ct};
      pr_p2_q <= {15'b0, rt_ray.a} * {16'b0, rt_ray.c};
      pr_m2_q <= {15'b0, rt_ray.b} * {16'b0, rt_ct};
    end
  end

  logic        ra_v, ra_zero;
  logic [24:0] ra_q1, ra_q2;

  fdr_ratio u_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pr_v_q),
    .p1_i    (pr_p1_q),
    .m1_i    (pr_m1_q),
    .p2_i    (pr_p2_q),
    .m2_i    (pr_m2_q),
    .valid_o (ra_v),
    .zero_o  (ra_zero),
    .q1_o    (ra_q1),
    .q2_o    (ra_q2)
  );

  // Squared ratios.
  logic        sq_v_q, sq_zero_q;
  logic [49:0] sq1_q, sq2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q <= 1'b0;
    end else if (en) begin
      sq_v_q <= ra_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_zero_q <= ra_zero;
      sq1_q     <= {25'b0, ra_q1} * {25'b0, ra_q1};
      sq2_q     <= {25'b0, ra_q2} * {25'b0, ra_q2};
    end
  end

  // Mean of the two squares, rounded half up to Q16, saturated at 1.0.
  logic [50:0] sq_sum;
  logic [17:0] refl_raw;
  logic [16:0] refl;
  assign sq_sum   = 51'(sq1_q) + 51'(sq2_q) + 51'd4294967296;
  assign refl_raw = sq_sum[50:33];
  assign refl     = (sq_zero_q || (refl_raw > 18'(OneQ16))) ? OneQ16 : refl_raw[16:0];

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_q      <= 1'b0;
    end else if (skid_q) begin
      if (out_free) begin
        out_valid_q <= 1'b1;
        skid_q      <= 1'b0;
      end
    end else if (sq_v_q) begin
      if (out_free) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_q <= 1'b1;
      end
    end else if (out_free) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_q) begin
      if (out_free) begin
        out_data_q <= skid_data_q;
      end
    end else if (sq_v_q) begin
      if (out_free) begin
        out_data_q <= refl;
      end else begin
        skid_data_q <= refl;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign reflectance_o = out_data_q;

  `FDR_ASSERT_SAME(a_refl_range, out_valid_q, out_data_q <= OneQ16, "reflectance above 1.0")
  `FDR_ASSERT_SAME(a_skid_has_out, skid_q, out_valid_q, "skid full with empty output")
  `FDR_ASSERT_NEXT(a_frozen, skid_q, $stable(sq_v_q) && $stable(sq1_q), "pipe moved while frozen")
  `FDR_ASSERT_NEXT(a_skid_drain, skid_q && !out_stall_i, !skid_q, "skid did not drain")

endmodule
